>>> src/kle_pkg.sv
// Shared constants, codes and control structs of the keyboard line editor.
package kle_pkg;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned LINE_DEPTH = 1024;
  localparam int unsigned MAX_READ   = 64;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned RING_AW = $clog2(RING_DEPTH);
  localparam int unsigned LINE_AW = $clog2(LINE_DEPTH);
  localparam int unsigned LEN_W   = $clog2(LINE_DEPTH + 1);
  localparam int unsigned SUM_W   = ((RING_AW > LEN_W) ? RING_AW : LEN_W) + 1;
  localparam int unsigned RD_W    = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;

  localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] PRINT_LOW     = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HIGH    = 8'h7e;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;

  typedef enum logic [1:0] {
    OK_ECHO = 2'd0,
    OK_LEFT = 2'd1,
    OK_DATA = 2'd2,
    OK_NONE = 2'd3
  } okind_e;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              commit;
    logic              rd_en;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  idx;
  } ring_cmd_t;

  typedef struct packed {
    logic [RING_AW-1:0] count;
    logic               empty;
  } ring_stat_t;

  typedef struct packed {
    logic               wr_en;
    logic [LINE_AW-1:0] wr_addr;
    logic [CHAR_W-1:0]  wr_data;
    logic               set_len;
    logic [LEN_W-1:0]   len;
    logic               rd_en;
    logic               advance;
  } line_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
  } line_stat_t;

endpackage

>>> src/kle_in_if.sv
// Request channel: key events and read requests.
interface kle_in_if;
  import kle_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [CHAR_W-1:0]  key_char;
  logic [LIMIT_W-1:0] read_limit;

  modport source (output valid, kind, key_char, read_limit, input ready);
  modport sink   (input valid, kind, key_char, read_limit, output ready);
endinterface

>>> src/kle_out_if.sv
// Result channel: echo, cursor moves and read data.
interface kle_out_if;
  import kle_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (output valid, out_kind, out_char, last, input ready);
  modport sink   (input valid, out_kind, out_char, last, output ready);
endinterface

>>> src/keyboard_line_editor_core.sv
// Keyboard line editor: sequencer over the pending ring and the line store.
// Printable key: pushed into the ring, echo loaded from ST_EMIT once the output register is free, then ready again.
// Backspace: three results, each loaded when the output register is free.
// Newline: copies n pending characters one per cycle, then echoes.
// Read: each returned byte passes through ST_RD_ADDR and ST_RD_DATA, as the line store read port is registered.
// Reset clears pointers, line length and read position; the stores are not cleared.
module keyboard_line_editor_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  kle_in_if.sink    in_i,
  kle_out_if.source out_o
);
  import kle_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_COPY    = 6'b000010,
    ST_EMIT    = 6'b000100,
    ST_BS      = 6'b001000,
    ST_RD_ADDR = 6'b010000,
    ST_RD_DATA = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d, num_q, num_d;
  logic               wr_v_q, wr_v_d;
  logic [LINE_AW-1:0] wr_addr_q, wr_addr_d;
  okind_e             kind_q, kind_d;
  logic [CHAR_W-1:0]  char_q, char_d;

  logic               out_valid_q, out_valid_d;
  okind_e             out_kind_q, out_kind_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_free;

  ring_cmd_t          ring_cmd;
  ring_stat_t         ring_stat;
  logic [CHAR_W-1:0]  ring_data;
  line_cmd_t          line_cmd;
  line_stat_t         line_stat;
  logic [CHAR_W-1:0]  line_data;

  logic               accept;
  logic [SUM_W-1:0]   nl_count;
  logic [LEN_W-1:0]   nl_num;
  logic [LIMIT_W-1:0] lim;
  logic [LEN_W-1:0]   avail;
  logic [RD_W-1:0]    rd_num;

  kle_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (ring_cmd),
    .stat_o    (ring_stat),
    .rd_data_o (ring_data)
  );

  kle_line u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (line_cmd),
    .stat_o    (line_stat),
    .rd_data_o (line_data)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Newline length, capped at the line store depth.
  always_comb begin
    nl_count = SUM_W'(ring_stat.count);
    if (nl_count > SUM_W'(LINE_DEPTH)) begin
      nl_count = SUM_W'(LINE_DEPTH);
    end
    nl_num = nl_count[LEN_W-1:0];
  end

  // Read length: min(unread bytes, saturated limit).
  always_comb begin
    lim    = (in_i.read_limit > LIMIT_W'(MAX_READ)) ? LIMIT_W'(MAX_READ) : in_i.read_limit;
    avail  = line_stat.len - line_stat.pos;
    rd_num = (RD_W'(avail) < RD_W'(lim)) ? RD_W'(avail) : RD_W'(lim);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    wr_v_d      = 1'b0;
    wr_addr_d   = wr_addr_q;
    kind_d      = kind_q;
    char_d      = char_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    ring_cmd    = '0;
    line_cmd    = '0;
    ring_cmd.ch  = in_i.key_char;
    ring_cmd.idx = cnt_q;
    line_cmd.wr_addr = wr_addr_q;
    line_cmd.wr_data = ring_data;
    line_cmd.len     = num_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (!in_i.kind) begin
            if (in_i.key_char == KEY_NEWLINE) begin
              num_d   = nl_num;
              state_d = ST_COPY;
            end else if (in_i.key_char == KEY_BACKSPACE) begin
              if (!ring_stat.empty) begin
                ring_cmd.pop = 1'b1;
                state_d      = ST_BS;
              end
            end else if (in_i.key_char >= PRINT_LOW && in_i.key_char <= PRINT_HIGH) begin
              ring_cmd.push = 1'b1;
              kind_d        = OK_ECHO;
              char_d        = in_i.key_char;
              state_d       = ST_EMIT;
            end
          end else if (line_stat.pos >= line_stat.len) begin
            kind_d  = OK_NONE;
            char_d  = '0;
            state_d = ST_EMIT;
          end else if (rd_num != '0) begin
            num_d   = LEN_W'(rd_num);
            state_d = ST_RD_ADDR;
          end
        end
      end
      ST_COPY: begin
        // ring read issued last cycle lands in the line store now
        line_cmd.wr_en = wr_v_q;
        if (cnt_q != num_q) begin
          ring_cmd.rd_en = 1'b1;
          wr_v_d         = 1'b1;
          wr_addr_d      = cnt_q[LINE_AW-1:0];
          cnt_d          = cnt_q + 1'b1;
        end else if (!wr_v_q) begin
          ring_cmd.commit  = 1'b1;
          line_cmd.set_len = 1'b1;
          kind_d           = OK_ECHO;
          char_d           = KEY_NEWLINE;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_char_d  = char_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_BS: begin
        // cursor left, space, cursor left
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = (cnt_q == LEN_W'(1)) ? OK_ECHO : OK_LEFT;
          out_char_d  = (cnt_q == LEN_W'(1)) ? CHAR_SPACE : '0;
          out_last_d  = (cnt_q == LEN_W'(2));
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == LEN_W'(2)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RD_ADDR: begin
        line_cmd.rd_en = 1'b1;
        state_d        = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_kind_d       = OK_DATA;
          out_char_d       = line_data;
          out_last_d       = (cnt_q + 1'b1 == num_q);
          line_cmd.advance = 1'b1;
          cnt_d            = cnt_q + 1'b1;
          state_d          = (cnt_q + 1'b1 == num_q) ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      wr_v_q      <= 1'b0;
      cnt_q       <= '0;
      num_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wr_v_q      <= wr_v_d;
      cnt_q       <= cnt_d;
      num_q       <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    kind_q     <= kind_d;
    char_q     <= char_d;
    out_kind_q <= out_kind_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_kind = out_kind_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;

  a_pos_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_stat.pos <= line_stat.len)
    else $error("line read position beyond line length");

  a_rd_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_DATA) |-> (cnt_q < num_q && num_q <= LEN_W'(MAX_READ)))
    else $error("read byte counter out of range");

  a_copy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (cnt_q <= num_q && num_q <= LEN_W'(LINE_DEPTH)))
    else $error("copy counter out of range");

  a_no_load_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(out_o.out_char))
    else $error("result overwritten before it was taken");

  a_bs_needs_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.kind && in_i.key_char == KEY_BACKSPACE && ring_stat.empty)
      |=> (state_q == ST_IDLE))
    else $error("backspace on empty ring started a sequence");
endmodule

>>> src/kle_ring.sv
// Pending character ring: storage, head/tail pointers and offset read port.
module kle_ring (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kle_pkg::ring_cmd_t cmd_i,
  output kle_pkg::ring_stat_t stat_o,
  output logic [kle_pkg::CHAR_W-1:0] rd_data_o
);
  import kle_pkg::*;

  logic [CHAR_W-1:0]  mem [RING_DEPTH];
  logic [RING_AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [RING_AW-1:0] head_inc, head_dec, tail_inc, rd_addr;
  logic [RING_AW:0]   count;
  logic [SUM_W-1:0]   sum;
  logic [CHAR_W-1:0]  rd_data_q;

  assign head_inc = (head_q == RING_AW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? RING_AW'(RING_DEPTH - 1) : head_q - 1'b1;
  assign tail_inc = (tail_q == RING_AW'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  assign count = {1'b0, head_q} - {1'b0, tail_q}
               + ((head_q < tail_q) ? (RING_AW + 1)'(RING_DEPTH) : '0);

  assign stat_o.count = count[RING_AW-1:0];
  assign stat_o.empty = (head_q == tail_q);

  // Offset from the oldest character, wrapped once.
  always_comb begin
    sum = SUM_W'(tail_q) + SUM_W'(cmd_i.idx);
    if (sum >= SUM_W'(RING_DEPTH)) begin
      sum = sum - SUM_W'(RING_DEPTH);
    end
    rd_addr = sum[RING_AW-1:0];
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (cmd_i.push) begin
      head_d = head_inc;
      // drop the oldest character when the ring fills
      if (head_inc == tail_q) begin
        tail_d = tail_inc;
      end
    end else if (cmd_i.pop) begin
      head_d = head_dec;
    end else if (cmd_i.commit) begin
      tail_d = head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[head_q] <= cmd_i.ch;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

>>> src/kle_line.sv
// Committed line store with its length and read position.
module kle_line (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kle_pkg::line_cmd_t cmd_i,
  output kle_pkg::line_stat_t stat_o,
  output logic [kle_pkg::CHAR_W-1:0] rd_data_o
);
  import kle_pkg::*;

  logic [CHAR_W-1:0] mem [LINE_DEPTH];
  logic [LEN_W-1:0]  len_q, pos_q;
  logic [CHAR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      pos_q <= '0;
    end else if (cmd_i.set_len) begin
      len_q <= cmd_i.len;
      pos_q <= '0;
    end else if (cmd_i.advance) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[pos_q[LINE_AW-1:0]];
    end
  end

  assign stat_o.len = len_q;
  assign stat_o.pos = pos_q;
  assign rd_data_o  = rd_data_q;
endmodule

>>> bench/keyboard_line_editor_core_tb.sv
// Self-checking bench for the keyboard line editor: directed table, random typing, long line.
module keyboard_line_editor_core_tb;
  import kle_pkg::*;

  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_READ = 1'b1;
  localparam int   STALL_LIMIT = 20000;

  typedef struct packed {
    okind_e           kind;
    logic [CHAR_W-1:0] ch;
    logic             last;
  } term_out_t;

  // n_res: -1 means check against the predictor, else the typed results below
  typedef struct {
    logic               kind;
    logic [CHAR_W-1:0]  key;
    logic [LIMIT_W-1:0] lim;
    int                 n_res;
    term_out_t          res;
  } dir_row_t;

  localparam term_out_t NO_OUT = '{OK_ECHO, 8'h00, 1'b0};

  logic clk_i = 1'b0;
  logic rst_ni;

  kle_in_if  in_if ();
  kle_out_if out_if ();

  keyboard_line_editor_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: pending ring and committed line
  logic [CHAR_W-1:0]  edit_buf [RING_DEPTH];
  logic [RING_AW-1:0] edit_wr  = '0;
  logic [RING_AW-1:0] edit_old = '0;
  logic [CHAR_W-1:0]  line_buf [LINE_DEPTH];
  logic [LEN_W-1:0]   line_pos = '0;
  logic [LEN_W-1:0]   line_len = '0;

  term_out_t term_out_q [$];
  int        failures     = 0;
  int        send_gap_pct = 0;
  int        recv_gap_pct = 0;
  int        hold_off_len = 0;
  int        stall_cycles = 0;

  dir_row_t dir_tab [23] = '{
    '{REQ_READ, 8'h00,         7'd5,   1, '{OK_NONE, 8'h00, 1'b1}},
    '{REQ_KEY,  KEY_BACKSPACE, 7'd0,   0, NO_OUT},
    '{REQ_KEY,  8'h00,         7'd0,   0, NO_OUT},
    '{REQ_KEY,  8'hff,         7'd0,   0, NO_OUT},
    '{REQ_KEY,  8'h1f,         7'd0,   0, NO_OUT},
    '{REQ_KEY,  8'h7f,         7'd0,   0, NO_OUT},
    '{REQ_KEY,  PRINT_LOW,     7'd0,   1, '{OK_ECHO, 8'h20, 1'b1}},
    '{REQ_KEY,  PRINT_HIGH,    7'h7f,  1, '{OK_ECHO, 8'h7e, 1'b1}},
    '{REQ_KEY,  8'h41,         7'd3,   1, '{OK_ECHO, 8'h41, 1'b1}},
    '{REQ_KEY,  KEY_BACKSPACE, 7'd0,  -1, NO_OUT},
    '{REQ_KEY,  KEY_NEWLINE,   7'd0,   1, '{OK_ECHO, 8'h0a, 1'b1}},
    '{REQ_READ, 8'h00,         7'd0,   0, NO_OUT},
    '{REQ_READ, 8'hff,         7'd1,  -1, NO_OUT},
    '{REQ_READ, 8'h00,         7'h7f, -1, NO_OUT},
    '{REQ_READ, 8'h00,         7'd64,  1, '{OK_NONE, 8'h00, 1'b1}},
    '{REQ_KEY,  KEY_NEWLINE,   7'd0,   1, '{OK_ECHO, 8'h0a, 1'b1}},
    '{REQ_READ, 8'h00,         7'd1,   1, '{OK_NONE, 8'h00, 1'b1}},
    '{REQ_KEY,  8'h70,         7'd0,   1, '{OK_ECHO, 8'h70, 1'b1}},
    '{REQ_KEY,  KEY_NEWLINE,   7'd0,   1, '{OK_ECHO, 8'h0a, 1'b1}},
    '{REQ_KEY,  8'h71,         7'd0,   1, '{OK_ECHO, 8'h71, 1'b1}},
    '{REQ_KEY,  KEY_NEWLINE,   7'd0,   1, '{OK_ECHO, 8'h0a, 1'b1}},
    '{REQ_READ, 8'h00,         7'd64, -1, NO_OUT},
    '{REQ_READ, 8'h00,         7'd65,  1, '{OK_NONE, 8'h00, 1'b1}}
  };

  function automatic int unsigned pending_count();
    return (32'(edit_wr) + RING_DEPTH - 32'(edit_old)) % RING_DEPTH;
  endfunction

  function automatic void edit_line_response(input logic kind, input logic [CHAR_W-1:0] key,
                                             input logic [LIMIT_W-1:0] lim,
                                             ref term_out_t resp[$]);
    int unsigned n, take, i;
    resp.delete();
    if (kind == REQ_KEY) begin
      if (key == KEY_NEWLINE) begin
        n = pending_count();
        if (n > LINE_DEPTH) n = LINE_DEPTH;
        for (i = 0; i < n; i++)
          line_buf[LINE_AW'(i)] = edit_buf[RING_AW'((32'(edit_old) + i) % RING_DEPTH)];
        edit_old = edit_wr;
        line_pos = '0;
        line_len = LEN_W'(n);
        resp.push_back(term_out_t'{OK_ECHO, key, 1'b1});
      end else if (key == KEY_BACKSPACE) begin
        if (edit_wr != edit_old) begin
          edit_wr = RING_AW'((32'(edit_wr) + RING_DEPTH - 1) % RING_DEPTH);
          resp.push_back(term_out_t'{OK_LEFT, 8'h00, 1'b0});
          resp.push_back(term_out_t'{OK_ECHO, CHAR_SPACE, 1'b0});
          resp.push_back(term_out_t'{OK_LEFT, 8'h00, 1'b1});
        end
      end else if (key >= PRINT_LOW && key <= PRINT_HIGH) begin
        edit_buf[edit_wr] = key;
        edit_wr = RING_AW'((32'(edit_wr) + 1) % RING_DEPTH);
        // full ring: drop the oldest character
        if (edit_wr == edit_old) edit_old = RING_AW'((32'(edit_old) + 1) % RING_DEPTH);
        resp.push_back(term_out_t'{OK_ECHO, key, 1'b1});
      end
    end else if (line_pos >= line_len) begin
      resp.push_back(term_out_t'{OK_NONE, 8'h00, 1'b1});
    end else begin
      take = (32'(lim) > MAX_READ) ? MAX_READ : 32'(lim);
      if (32'(line_len - line_pos) < take) take = 32'(line_len - line_pos);
      for (i = 0; i < take; i++)
        resp.push_back(term_out_t'{OK_DATA, line_buf[LINE_AW'(32'(line_pos) + i)],
                                   i + 1 == take});
      line_pos = LEN_W'(32'(line_pos) + take);
    end
  endfunction

  task automatic send_req(input logic kind, input logic [CHAR_W-1:0] key,
                          input logic [LIMIT_W-1:0] lim, input int fixed_n,
                          input term_out_t fixed_res, output int caused);
    term_out_t resp [$];
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.key_char   <= key;
    in_if.read_limit <= lim;
    do @(posedge clk_i); while (!in_if.ready);
    edit_line_response(kind, key, lim, resp);
    caused = resp.size();
    if (fixed_n < 0) begin
      foreach (resp[k]) term_out_q.push_back(resp[k]);
    end else if (fixed_n == 1) begin
      term_out_q.push_back(fixed_res);
    end
  endtask

  // Hold the input idle until every awaited output has arrived
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (term_out_q.size() != 0);
  endtask

  // One line with some noise, committed by a newline most of the time, then up to three reads
  task automatic type_session(output int caused);
    int                n, r, len;
    logic [CHAR_W-1:0] c;
    caused = 0;
    len = ($urandom_range(9) == 0) ? int'($urandom_range(150, 40))
                                   : int'($urandom_range(12, 0));
    repeat (len) begin
      r = int'($urandom_range(99));
      if (r < 84) c = CHAR_W'($urandom_range(PRINT_HIGH, PRINT_LOW));
      else if (r < 94) c = KEY_BACKSPACE;
      else c = CHAR_W'($urandom_range(255));
      send_req(REQ_KEY, c, LIMIT_W'($urandom_range(127)), -1, NO_OUT, n);
      caused += int'(n != 0);
    end
    if ($urandom_range(9) != 0) begin
      send_req(REQ_KEY, KEY_NEWLINE, LIMIT_W'($urandom_range(127)), -1, NO_OUT, n);
      caused += int'(n != 0);
    end
    repeat ($urandom_range(3)) begin
      send_req(REQ_READ, CHAR_W'($urandom_range(255)),
               LIMIT_W'(($urandom_range(4) == 0) ? $urandom_range(127)
                                                  : $urandom_range(MAX_READ, 1)),
               -1, NO_OUT, n);
      caused += int'(n != 0);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        out_if.ready <= 1'b0;
        hold_off_len = hold_off_len - 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    term_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (term_out_q.size() == 0) begin
        $error("output with none awaited: out_kind %0d, out_char %02h, last %0b",
               out_if.out_kind, out_if.out_char, out_if.last);
        failures++;
      end else begin
        want = term_out_q.pop_front();
        if (out_if.out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_if.out_kind);
          failures++;
        end
        if (out_if.out_char !== want.ch) begin
          $error("out_char: expected %02h, got %02h", want.ch, out_if.out_char);
          failures++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int caused, done_items, phase;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = REQ_KEY;
    in_if.key_char   = '0;
    in_if.read_limit = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r])
      send_req(dir_tab[r].kind, dir_tab[r].key, dir_tab[r].lim, dir_tab[r].n_res,
               dir_tab[r].res, caused);

    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 15 : (phase == 1) ? 58 : 0;
      recv_gap_pct = (phase == 0) ? 58 : (phase == 1) ? 15 : 0;
      // long output stall while requests keep coming
      if (phase == 0) hold_off_len = 300;
      done_items = 0;
      while (done_items < 75) begin
        type_session(caused);
        done_items += caused;
      end
      wait_drained();
    end

    // Commit whatever is pending and read the line out to the end
    send_req(REQ_KEY, KEY_NEWLINE, 7'd0, -1, NO_OUT, caused);
    while (line_pos < line_len)
      send_req(REQ_READ, CHAR_W'($urandom_range(255)), LIMIT_W'(MAX_READ), -1, NO_OUT,
               caused);
    send_req(REQ_READ, 8'h00, LIMIT_W'(MAX_READ), -1, NO_OUT, caused);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/kle_pkg.sv
src/kle_in_if.sv
src/kle_out_if.sv
src/kle_ring.sv
src/kle_line.sv
src/keyboard_line_editor_core.sv
bench/keyboard_line_editor_core_tb.sv
